// File: design/fsi_pkg.sv
// Shared types, constants and helpers for the fuzzy speed scale inference block.
// Used by every file of the block; depends on nothing.
package fsi_pkg;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned ONE_Q     = 1 << FRAC_BITS;

  localparam int unsigned ST_W      = 3;
  localparam int unsigned OFF_W     = 19;
  localparam int unsigned DST_W     = 13;
  localparam int unsigned CTR_W     = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned MEMB_W    = FRAC_BITS + 1;
  localparam int unsigned W_W       = MEMB_W + 2;
  localparam int unsigned PROD_W    = W_W + CTR_W;

  localparam int unsigned DIV_N_W   = 32;
  localparam int unsigned DIV_D_W   = 16;
  localparam int unsigned DIV_L_W   = DIV_N_W - DIV_D_W;
  localparam int unsigned DIV_STEPS = DIV_L_W;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int unsigned NUM_CTR = 4;
  localparam int unsigned NUM_DIV = 5;

  // breakpoints, real value times 2^F rounded half up
  localparam int unsigned OFF_MED_A   = ((11 << FRAC_BITS) + 10) / 20;
  localparam int unsigned OFF_MED_B   = ((11 << FRAC_BITS) + 5) / 10;
  localparam int unsigned OFF_NEAR_C  = ((6 << FRAC_BITS) + 2) / 5;
  localparam int unsigned OFF_FAR_A   = ((21 << FRAC_BITS) + 5) / 10;
  localparam int unsigned OFF_FAR_B   = ((31 << FRAC_BITS) + 5) / 10;
  localparam int unsigned OFF_FAR_C   = 100 << FRAC_BITS;
  localparam int unsigned DST_MED_A   = ((3 << FRAC_BITS) + 25) / 50;
  localparam int unsigned DST_CLOSE_C = ((3 << FRAC_BITS) + 10) / 20;
  localparam int unsigned DST_MED_B   = ((1 << FRAC_BITS) + 2) / 5;
  localparam int unsigned DST_FAR_B   = 1 << FRAC_BITS;

  // slope division by constant: floor((dx << F) / D) = (dx * ceil(2^K / D)) >> (K - F),
  // exact for dx below 2^MEMB_W since K is no less than dividend plus divisor bits
  localparam int unsigned     RCP_K   = 38;
  localparam int unsigned     RCP_W   = 29;
  localparam int unsigned     RCP_P_W = MEMB_W + RCP_W;
  localparam int unsigned     RCP_SH  = RCP_K - FRAC_BITS;
  localparam longint unsigned RCP_ONE = 64'd1 << RCP_K;

  localparam logic [RCP_W-1:0] RCP_NEAR  =
    RCP_W'((RCP_ONE + OFF_NEAR_C - 1) / OFF_NEAR_C);
  localparam logic [RCP_W-1:0] RCP_MED   =
    RCP_W'((RCP_ONE + (OFF_MED_B - OFF_MED_A) - 1) / (OFF_MED_B - OFF_MED_A));
  localparam logic [RCP_W-1:0] RCP_CLOSE =
    RCP_W'((RCP_ONE + DST_CLOSE_C - 1) / DST_CLOSE_C);
  localparam logic [RCP_W-1:0] RCP_DMED  =
    RCP_W'((RCP_ONE + (DST_MED_B - DST_MED_A) - 1) / (DST_MED_B - DST_MED_A));
  localparam logic [RCP_W-1:0] RCP_DFAR  =
    RCP_W'((RCP_ONE + (DST_FAR_B - DST_MED_B) - 1) / (DST_FAR_B - DST_MED_B));

  // control state codes
  localparam logic [ST_W-1:0] ST_NONE = ST_W'(0);
  localparam logic [ST_W-1:0] ST_GO   = ST_W'(1);
  localparam logic [ST_W-1:0] ST_SLOW = ST_W'(2);
  localparam logic [ST_W-1:0] ST_STOP = ST_W'(3);
  localparam logic [ST_W-1:0] ST_FAR  = ST_W'(4);

  // register indexes, also the output centre groups
  localparam logic [CFG_IDX_W-1:0] CFG_STOP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_FULL = CFG_IDX_W'(3);

  localparam int unsigned G_STOP = 0;
  localparam int unsigned G_SLOW = 1;
  localparam int unsigned G_KEEP = 2;
  localparam int unsigned G_FULL = 3;

  // membership slope lanes
  localparam int unsigned M_NEAR  = 0;
  localparam int unsigned M_MED   = 1;
  localparam int unsigned M_CLOSE = 2;
  localparam int unsigned M_DMED  = 3;
  localparam int unsigned M_DFAR  = 4;

  typedef logic [NUM_CTR-1:0][CTR_W-1:0] ctr_arr_t;

  localparam ctr_arr_t CTR_RST = {CTR_W'(4096), CTR_W'(2662), CTR_W'(1434), CTR_W'(0)};

  typedef enum logic [2:0] {
    K_NONE,
    K_GO,
    K_SLOW,
    K_STOP,
    K_FAR,
    K_IDLE
  } kind_e;

  typedef struct packed {
    logic              use_div;
    logic [MEMB_W-1:0] direct;
    logic [MEMB_W-1:0] dx;
  } memb_t;

  typedef struct packed {
    kind_e                     kind;
    memb_t [NUM_DIV-1:0]       memb;
    logic  [MEMB_W-1:0]        far;
  } item_t;

  function automatic logic [RCP_W-1:0] rcp_const(input int unsigned lane);
    logic [RCP_W-1:0] r;
    unique case (lane)
      M_NEAR:  r = RCP_NEAR;
      M_MED:   r = RCP_MED;
      M_CLOSE: r = RCP_CLOSE;
      M_DMED:  r = RCP_DMED;
      M_DFAR:  r = RCP_DFAR;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [MEMB_W-1:0] mmin(input logic [MEMB_W-1:0] a,
                                              input logic [MEMB_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [MEMB_W-1:0] mmax(input logic [MEMB_W-1:0] a,
                                              input logic [MEMB_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: design/fsi_if.sv
// Channel interfaces of the fuzzy speed scale block: input items, results and
// configuration writes. Depends on fsi_pkg.
interface fsi_in_if;
  import fsi_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   control_state;
  logic [OFF_W-1:0]  lat_offset;
  logic [DST_W-1:0]  obst_dist;
  modport source (output valid, control_state, lat_offset, obst_dist, input ready);
  modport sink   (input valid, control_state, lat_offset, obst_dist, output ready);
endinterface

interface fsi_out_if;
  import fsi_pkg::*;
  logic             valid;
  logic             ready;
  logic [CTR_W-1:0] speed_scale;
  logic             no_rule_fired;
  modport source (output valid, speed_scale, no_rule_fired, input ready);
  modport sink   (input valid, speed_scale, no_rule_fired, output ready);
endinterface

interface fsi_cfg_if;
  import fsi_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CTR_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/fsi_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on fsi_pkg; quotient must fit DIV_STEPS bits.
module fsi_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [fsi_pkg::DIV_N_W-1:0] dividend_i,
  input  logic [fsi_pkg::DIV_D_W-1:0] divisor_i,
  output logic [fsi_pkg::DIV_L_W-1:0] quotient_o
);
  import fsi_pkg::*;

  logic [DIV_D_W-1:0] rem_q [DIV_STEPS];
  logic [DIV_L_W-1:0] low_q [DIV_STEPS];
  logic [DIV_L_W-1:0] quo_q [DIV_STEPS];
  logic [DIV_D_W-1:0] dvs_q [DIV_STEPS];
  logic [DIV_D_W-1:0] rem_d [DIV_STEPS];
  logic [DIV_L_W-1:0] low_d [DIV_STEPS];
  logic [DIV_L_W-1:0] quo_d [DIV_STEPS];
  logic [DIV_D_W-1:0] dvs_d [DIV_STEPS];
  logic [DIV_D_W-1:0] rem_s [DIV_STEPS+1];
  logic [DIV_L_W-1:0] low_s [DIV_STEPS+1];
  logic [DIV_L_W-1:0] quo_s [DIV_STEPS+1];
  logic [DIV_D_W-1:0] dvs_s [DIV_STEPS+1];

  always_comb begin
    rem_s[0] = dividend_i[DIV_N_W-1:DIV_L_W];
    low_s[0] = dividend_i[DIV_L_W-1:0];
    quo_s[0] = '0;
    dvs_s[0] = divisor_i;
    for (int s = 0; s < DIV_STEPS; s++) begin
      rem_s[s+1] = rem_q[s];
      low_s[s+1] = low_q[s];
      quo_s[s+1] = quo_q[s];
      dvs_s[s+1] = dvs_q[s];
    end
  end

  always_comb begin
    logic [DIV_D_W:0] trial;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial = {rem_s[s], low_s[s][DIV_L_W-1]};
      if (trial >= {1'b0, dvs_s[s]}) begin
        rem_d[s] = DIV_D_W'(trial - {1'b0, dvs_s[s]});
        quo_d[s] = {quo_s[s][DIV_L_W-2:0], 1'b1};
      end else begin
        rem_d[s] = trial[DIV_D_W-1:0];
        quo_d[s] = {quo_s[s][DIV_L_W-2:0], 1'b0};
      end
      low_d[s] = {low_s[s][DIV_L_W-2:0], 1'b0};
      dvs_d[s] = dvs_s[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      low_q <= low_d;
      quo_q <= quo_d;
      dvs_q <= dvs_d;
    end
  end

  assign quotient_o = quo_q[DIV_STEPS-1];

endmodule

// File: design/fsi_fifo.sv
// Short queue of classified items between the front and the back end.
// Depends on fsi_pkg.
module fsi_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fsi_pkg::item_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output fsi_pkg::item_t data_o,
  output logic           valid_o
);
  import fsi_pkg::*;

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: design/fsi_front.sv
// Front end: accepts input beats and classifies offset and distance into
// membership segments for the back end. Depends on fsi_pkg and fsi_if.
module fsi_front (
  fsi_in_if.sink         in_i,
  input  logic           full_i,
  output logic           push_o,
  output fsi_pkg::item_t item_o
);
  import fsi_pkg::*;

  logic [OFF_W-1:0] x;
  logic [DST_W-1:0] d;

  assign x      = in_i.lat_offset;
  assign d      = in_i.obst_dist;
  assign in_i.ready = !full_i;
  assign push_o = in_i.valid && !full_i;

  always_comb begin
    item_o = '0;
    unique case (in_i.control_state)
      ST_NONE: item_o.kind = K_NONE;
      ST_GO:   item_o.kind = K_GO;
      ST_SLOW: item_o.kind = K_SLOW;
      ST_STOP: item_o.kind = K_STOP;
      ST_FAR:  item_o.kind = K_FAR;
      default: item_o.kind = K_IDLE;
    endcase

    // offset near: falling from zero
    if (x < OFF_W'(OFF_NEAR_C)) begin
      item_o.memb[M_NEAR].use_div = 1'b1;
      item_o.memb[M_NEAR].dx      = MEMB_W'(OFF_W'(OFF_NEAR_C) - x);
    end

    // offset medium
    if (x == OFF_W'(OFF_MED_B)) begin
      item_o.memb[M_MED].direct = MEMB_W'(ONE_Q);
    end else if (x <= OFF_W'(OFF_MED_A) || x >= OFF_W'(OFF_FAR_A)) begin
      item_o.memb[M_MED].direct = '0;
    end else if (x < OFF_W'(OFF_MED_B)) begin
      item_o.memb[M_MED].use_div = 1'b1;
      item_o.memb[M_MED].dx      = MEMB_W'(x - OFF_W'(OFF_MED_A));
    end else begin
      item_o.memb[M_MED].direct = MEMB_W'(OFF_W'(OFF_FAR_A) - x);
    end

    // offset far: unit-width rising edge
    if (x <= OFF_W'(OFF_FAR_A)) begin
      item_o.far = '0;
    end else if (x < OFF_W'(OFF_FAR_B)) begin
      item_o.far = MEMB_W'(x - OFF_W'(OFF_FAR_A));
    end else if (x < OFF_W'(OFF_FAR_C)) begin
      item_o.far = MEMB_W'(ONE_Q);
    end else begin
      item_o.far = '0;
    end

    // distance close
    if (d < DST_W'(DST_CLOSE_C)) begin
      item_o.memb[M_CLOSE].use_div = 1'b1;
      item_o.memb[M_CLOSE].dx      = MEMB_W'(DST_W'(DST_CLOSE_C) - d);
    end

    // distance medium
    if (d == DST_W'(DST_MED_B)) begin
      item_o.memb[M_DMED].direct = MEMB_W'(ONE_Q);
    end else if (d > DST_W'(DST_MED_A) && d < DST_W'(DST_MED_B)) begin
      item_o.memb[M_DMED].use_div = 1'b1;
      item_o.memb[M_DMED].dx      = MEMB_W'(d - DST_W'(DST_MED_A));
    end

    // distance far
    if (d == DST_W'(DST_FAR_B)) begin
      item_o.memb[M_DFAR].direct = MEMB_W'(ONE_Q);
    end else if (d > DST_W'(DST_MED_B) && d < DST_W'(DST_FAR_B)) begin
      item_o.memb[M_DFAR].use_div = 1'b1;
      item_o.memb[M_DFAR].dx      = MEMB_W'(d - DST_W'(DST_MED_B));
    end
  end

endmodule

// File: design/fsi_back.sv
// Back end: reciprocal-multiply memberships, rule strengths, weighted sum and
// the averaging divider, stalled as one pipeline. Depends on fsi_pkg, fsi_div, fsi_if.
module fsi_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fsi_pkg::item_t    head_i,
  input  logic              head_valid_i,
  output logic              pop_o,
  input  fsi_pkg::ctr_arr_t centers_i,
  fsi_out_if.source         out_o
);
  import fsi_pkg::*;

  logic adv;

  // membership stage
  logic [MEMB_W-1:0]     m_d [NUM_DIV];
  logic [MEMB_W-1:0]     m_q [NUM_DIV];
  kind_e                 kind_q;
  logic [MEMB_W-1:0]     far_q;
  logic                  v1_q;

  // rule strength and product stages
  logic [W_W-1:0]        g_d [NUM_CTR];
  logic [W_W-1:0]        g_q [NUM_CTR];
  logic                  vm_q;
  logic [PROD_W-1:0]     prod_q [NUM_CTR];
  logic [W_W-1:0]        den_q;
  logic                  vn_q;

  // averaging divider segment
  logic [DIV_N_W-1:0]    num;
  logic [DIV_L_W-1:0]    avg;
  logic [DIV_STEPS-1:0]  v2_q;
  logic [DIV_STEPS-1:0]  nf_q;

  logic                  ovalid_q;
  logic [CTR_W-1:0]      speed_q;
  logic                  nofire_q;

  assign adv   = !ovalid_q || out_o.ready;
  assign pop_o = adv && head_valid_i;

  always_comb begin
    logic [RCP_P_W-1:0] prod;
    for (int unsigned i = 0; i < NUM_DIV; i++) begin
      prod   = RCP_P_W'(head_i.memb[i].dx) * RCP_P_W'(rcp_const(i));
      m_d[i] = head_i.memb[i].use_div ? MEMB_W'(prod >> RCP_SH) : head_i.memb[i].direct;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q    <= m_d;
      kind_q <= head_i.kind;
      far_q  <= head_i.far;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CTR; k++) begin
      g_d[k] = '0;
    end
    unique case (kind_q)
      K_SLOW: begin
        g_d[G_STOP] = W_W'(mmin(m_q[M_NEAR], m_q[M_CLOSE]));
        g_d[G_SLOW] = W_W'(mmin(m_q[M_NEAR], m_q[M_DMED])) + W_W'(m_q[M_MED]);
        g_d[G_KEEP] = W_W'(mmin(m_q[M_NEAR], m_q[M_DFAR])) + W_W'(far_q);
      end
      K_STOP: g_d[G_STOP] = W_W'(ONE_Q);
      K_GO:   g_d[G_KEEP] = W_W'(mmax(m_q[M_NEAR], m_q[M_MED]));
      K_FAR:  g_d[G_KEEP] = W_W'(ONE_Q);
      K_NONE: g_d[G_FULL] = W_W'(ONE_Q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_q <= g_d;
      for (int k = 0; k < NUM_CTR; k++) begin
        prod_q[k] <= PROD_W'(g_q[k]) * PROD_W'(centers_i[k]);
      end
      den_q <= g_q[G_STOP] + g_q[G_SLOW] + g_q[G_KEEP] + g_q[G_FULL];
    end
  end

  assign num = DIV_N_W'(prod_q[G_STOP]) + DIV_N_W'(prod_q[G_SLOW])
             + DIV_N_W'(prod_q[G_KEEP]) + DIV_N_W'(prod_q[G_FULL])
             + DIV_N_W'(den_q >> 1);

  fsi_div u_avg_div (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (num),
    .divisor_i  (DIV_D_W'(den_q)),
    .quotient_o (avg)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nf_q     <= {nf_q[DIV_STEPS-2:0], (den_q == '0)};
      speed_q  <= nf_q[DIV_STEPS-1] ? centers_i[G_FULL] : CTR_W'(avg);
      nofire_q <= nf_q[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      vm_q     <= 1'b0;
      vn_q     <= 1'b0;
      v2_q     <= '0;
      ovalid_q <= 1'b0;
    end else if (adv) begin
      v1_q     <= head_valid_i;
      vm_q     <= v1_q;
      vn_q     <= vm_q;
      v2_q     <= {v2_q[DIV_STEPS-2:0], vn_q};
      ovalid_q <= v2_q[DIV_STEPS-1];
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.speed_scale   = speed_q;
  assign out_o.no_rule_fired = nofire_q;

endmodule

// File: design/fuzzy_speed_scale_inference.sv
// Fuzzy speed scale inference: one result beat per input beat, in order. An
// input beat is written into a four-entry queue at its accepting edge; the back
// end then passes it through the membership register, the rule strength and
// product registers, the averaging divider stages and the output register, in
// that order. Every stage is pipelined, so a new beat is taken every cycle while
// results are drained; a held result stalls the whole back end and the queue
// then fills and stalls the input. The user must write centre registers only
// while no beat is in flight; the block itself does not enforce it.
module fuzzy_speed_scale_inference (
  input  logic       clk_i,
  input  logic       rst_ni,
  fsi_in_if.sink     in_i,
  fsi_cfg_if.sink    cfg_i,
  fsi_out_if.source  out_o
);
  import fsi_pkg::*;

  ctr_arr_t ctr_q;
  item_t    push_item, head_item;
  logic     push, full, pop, head_valid;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= CTR_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_STOP: ctr_q[G_STOP] <= cfg_i.data;
        CFG_SLOW: ctr_q[G_SLOW] <= cfg_i.data;
        CFG_KEEP: ctr_q[G_KEEP] <= cfg_i.data;
        CFG_FULL: ctr_q[G_FULL] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  fsi_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  fsi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_item),
    .valid_o (head_valid)
  );

  fsi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_item),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .centers_i    (ctr_q),
    .out_o        (out_o)
  );

endmodule
